/* rtl/cip_pkg.sv */
// cip_pkg: shared types, constants and edge/face tables of the cell isosurface polygon block
// no dependencies
package cip_pkg;

    localparam int MAX_VERTICES  = 6;
    localparam int MAX_EDGES     = 9;
    localparam int MAX_SEGMENTS  = 5;
    localparam int MAX_POINTS    = 6;
    localparam int FRAC_BITS_DEF = 16;

    // register indexes of the configuration port
    localparam logic [1:0] REG_ISO_LEVEL = 2'd0;
    localparam logic [1:0] REG_CELL_TYPE = 2'd1;
    localparam logic [1:0] REG_MIN_DEN   = 2'd2;

    // end-of-list mark in a face edge list
    localparam logic [3:0] EDGE_NONE = 4'hF;

    // one cell worth of vertices plus the configuration it runs under
    typedef struct packed {
        logic [MAX_VERTICES-1:0][31:0] vx;
        logic [MAX_VERTICES-1:0][31:0] vy;
        logic [MAX_VERTICES-1:0][31:0] vz;
        logic [MAX_VERTICES-1:0][31:0] vv;
        logic [31:0]                   iso;
        logic                          tet;
        logic [15:0]                   min_den;
    } cip_job_t;

    // one result word
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [2:0]  num;
        logic        has;
        logic        last;
    } cip_point_t;

    // start vertex of an edge
    function automatic logic [2:0] edge_start(input logic tet, input logic [3:0] e);
        logic [2:0] v;
        unique case (e)
            4'd0, 4'd3: v = 3'd0;
            4'd1, 4'd4: v = 3'd1;
            4'd2, 4'd5: v = 3'd2;
            4'd6:       v = tet ? 3'd0 : 3'd3;
            4'd7:       v = tet ? 3'd0 : 3'd4;
            4'd8:       v = tet ? 3'd0 : 3'd5;
            default:    v = 3'd0;
        endcase
        return v;
    endfunction

    // end vertex of an edge
    function automatic logic [2:0] edge_end(input logic tet, input logic [3:0] e);
        logic [2:0] v;
        unique case (e)
            4'd0:    v = 3'd1;
            4'd1:    v = 3'd2;
            4'd2:    v = 3'd0;
            4'd3:    v = 3'd3;
            4'd4:    v = tet ? 3'd3 : 3'd4;
            4'd5:    v = tet ? 3'd3 : 3'd5;
            4'd6:    v = tet ? 3'd0 : 3'd4;
            4'd7:    v = tet ? 3'd0 : 3'd5;
            4'd8:    v = tet ? 3'd0 : 3'd3;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // prism vertical edges exclude the upper bound
    function automatic logic edge_strict(input logic tet, input logic [3:0] e);
        return !tet && (e == 4'd3 || e == 4'd4 || e == 4'd5);
    endfunction

    // entry i of the edge list of face f
    function automatic logic [3:0] face_edge(input logic tet, input logic [2:0] f,
                                             input logic [1:0] i);
        logic [3:0] r;
        r = EDGE_NONE;
        if (tet)
        begin
            unique case ({f, i})
                {3'd0, 2'd0}: r = 4'd0;
                {3'd0, 2'd1}: r = 4'd1;
                {3'd0, 2'd2}: r = 4'd2;
                {3'd1, 2'd0}: r = 4'd0;
                {3'd1, 2'd1}: r = 4'd4;
                {3'd1, 2'd2}: r = 4'd3;
                {3'd2, 2'd0}: r = 4'd1;
                {3'd2, 2'd1}: r = 4'd5;
                {3'd2, 2'd2}: r = 4'd4;
                {3'd3, 2'd0}: r = 4'd2;
                {3'd3, 2'd1}: r = 4'd3;
                {3'd3, 2'd2}: r = 4'd5;
                default:      r = EDGE_NONE;
            endcase
        end
        else
        begin
            unique case ({f, i})
                {3'd0, 2'd0}: r = 4'd0;
                {3'd0, 2'd1}: r = 4'd1;
                {3'd0, 2'd2}: r = 4'd2;
                {3'd1, 2'd0}: r = 4'd0;
                {3'd1, 2'd1}: r = 4'd4;
                {3'd1, 2'd2}: r = 4'd6;
                {3'd1, 2'd3}: r = 4'd3;
                {3'd2, 2'd0}: r = 4'd1;
                {3'd2, 2'd1}: r = 4'd4;
                {3'd2, 2'd2}: r = 4'd7;
                {3'd2, 2'd3}: r = 4'd5;
                {3'd3, 2'd0}: r = 4'd2;
                {3'd3, 2'd1}: r = 4'd5;
                {3'd3, 2'd2}: r = 4'd8;
                {3'd3, 2'd3}: r = 4'd3;
                {3'd4, 2'd0}: r = 4'd6;
                {3'd4, 2'd1}: r = 4'd7;
                {3'd4, 2'd2}: r = 4'd8;
                default:      r = EDGE_NONE;
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/cip_front.sv */
// cip_front: configuration registers, vertex store and two-entry cell job queue
// depends on cip_pkg
module cip_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         vertex_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] scalar_value,
    input  logic               last_vertex,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               job_valid,
    output cip_pkg::cip_job_t  job,
    input  logic               job_pop
);
    import cip_pkg::*;

    logic [31:0] iso_reg;
    logic        tet_reg;
    logic [15:0] min_den_reg;

    logic [MAX_VERTICES-1:0][31:0] vx_reg, vy_reg, vz_reg, vv_reg;

    cip_job_t    q_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept, vi_ok, enq, deq;
    cip_job_t    job_in;

    assign full   = (cnt_reg == 2'd2);
    assign accept = push && !full;
    assign vi_ok  = (vertex_index < 3'(MAX_VERTICES));
    assign enq    = accept && last_vertex;
    assign deq    = job_pop && job_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_reg     <= '0;
            tet_reg     <= 1'b0;
            min_den_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ISO_LEVEL: iso_reg     <= cfg_data;
                REG_CELL_TYPE: tet_reg     <= cfg_data[0];
                REG_MIN_DEN:   min_den_reg <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // vertex store
    always_ff @(posedge clk)
    begin
        if (accept && vi_ok)
        begin
            vx_reg[vertex_index] <= pos_x;
            vy_reg[vertex_index] <= pos_y;
            vz_reg[vertex_index] <= pos_z;
            vv_reg[vertex_index] <= scalar_value;
        end
    end

    // snapshot of the cell including the vertex of this word
    always_comb
    begin
        job_in.vx      = vx_reg;
        job_in.vy      = vy_reg;
        job_in.vz      = vz_reg;
        job_in.vv      = vv_reg;
        job_in.iso     = iso_reg;
        job_in.tet     = tet_reg;
        job_in.min_den = min_den_reg;
        if (vi_ok)
        begin
            job_in.vx[vertex_index] = pos_x;
            job_in.vy[vertex_index] = pos_y;
            job_in.vz[vertex_index] = pos_z;
            job_in.vv[vertex_index] = scalar_value;
        end
    end

    // job queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wptr_reg] <= job_in;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // job queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (enq)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (deq)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rptr_reg];

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("job queue count out of range");
    a_no_enq_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> cnt_reg != 2'd0 || $past(deq))
        else $error("job queue lost an entry");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (enq && !deq) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("job queue count did not follow a push");

endmodule

/* rtl/cip_outq.sv */
// cip_outq: two-entry result queue in front of the result ports
// depends on cip_pkg
module cip_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_push,
    input  cip_pkg::cip_point_t in_item,
    output logic                in_full,
    output logic                empty,
    input  logic                pop,
    output cip_pkg::cip_point_t out_item
);
    import cip_pkg::*;

    cip_point_t q_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       enq, deq;

    assign in_full  = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign enq      = in_push && !in_full;
    assign deq      = pop && !empty;
    assign out_item = q_reg[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wptr_reg] <= in_item;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (enq)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (deq)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (enq && !deq)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (deq && !enq)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/cip_back.sv */
// cip_back: edge sequencer with shared divider and multiplier, polygon builder, emitter
// depends on cip_pkg
module cip_back #(
    parameter int FRAC_BITS = cip_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  cip_pkg::cip_job_t   job,
    output logic                job_pop,
    output logic                out_push,
    output cip_pkg::cip_point_t out_item,
    input  logic                out_full
);
    import cip_pkg::*;

    localparam int TW = FRAC_BITS + 1;
    localparam int CW = $clog2(TW);
    localparam int PW = 33 + TW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_ADD  = 4'd4;
    localparam logic [3:0] S_SEG  = 4'd5;
    localparam logic [3:0] S_CHN  = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;
    localparam logic [3:0] S_EMWR = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  e_reg, e_next;
    logic [3:0]  ncross_reg, ncross_next;
    logic [MAX_EDGES-1:0] crossed_reg, crossed_next;
    logic [MAX_POINTS-1:0][3:0] order_reg, order_next;
    logic [2:0]  npoly_reg, npoly_next;
    logic [2:0]  k_reg, k_next;
    logic        nopoly_reg, nopoly_next;
    logic        tet_reg, tet_next;
    logic [2:0]  f_reg, f_next;
    logic [2:0]  nseg_reg, nseg_next;
    logic [MAX_SEGMENTS-1:0][7:0] seg_reg, seg_next;
    logic [MAX_SEGMENTS-1:0] used_reg, used_next;
    logic [3:0]  start_reg, start_next;
    logic [3:0]  next_reg, next_next;
    logic [33:0] rem_reg, rem_next;
    logic [TW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [32:0] aden_reg, aden_next;
    logic [1:0]  crd_reg, crd_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [31:0] px_reg, px_next, py_reg, py_next;

    logic [95:0] mem [MAX_EDGES];
    logic [95:0] rd_reg;
    logic        mem_we;
    logic [31:0] sum;

    // edge evaluation signals
    logic [2:0]  vs_i, ve_i;
    logic signed [32:0] num, den;
    logic [32:0] anum, aden;
    logic        edge_ok, strict;
    logic [3:0]  nedge;
    logic [2:0]  nface;
    logic signed [31:0] ps, pe;
    logic signed [32:0] diff;
    logic signed [PW-1:0] off;
    logic [33:0] cand;
    logic        qbit;

    // face scan signals
    logic [3:0]  fe, seg_a, seg_b;
    logic        fa_found, fb_found, f_stop;

    // chain search signals
    logic [3:0]  ca, cb, cnext;
    logic        c_found;
    logic [2:0]  c_sel;

    assign nedge = tet_reg ? 4'd6 : 4'(MAX_EDGES);
    assign nface = tet_reg ? 3'd4 : 3'(MAX_SEGMENTS);

    // crossing test of the current edge
    always_comb
    begin
        vs_i   = edge_start(job.tet, e_reg);
        ve_i   = edge_end(job.tet, e_reg);
        strict = edge_strict(job.tet, e_reg);
        num    = $signed({job.iso[31], job.iso}) - $signed({job.vv[vs_i][31], job.vv[vs_i]});
        den    = $signed({job.vv[ve_i][31], job.vv[ve_i]})
                 - $signed({job.vv[vs_i][31], job.vv[vs_i]});
        anum   = num[32] ? 33'(-num) : 33'(num);
        aden   = den[32] ? 33'(-den) : 33'(den);
        if (den == '0 || aden < {17'd0, job.min_den})
        begin
            edge_ok = 1'b0;
        end
        else if (!den[32])
        begin
            edge_ok = (num > 0) && (strict ? (num < den) : (num <= den));
        end
        else
        begin
            edge_ok = (num < 0) && (strict ? (num > den) : (num >= den));
        end
    end

    // coordinate selection and interpolation
    always_comb
    begin
        unique case (crd_reg)
            2'd0:
            begin
                ps = job.vx[vs_i];
                pe = job.vx[ve_i];
            end
            2'd1:
            begin
                ps = job.vy[vs_i];
                pe = job.vy[ve_i];
            end
            default:
            begin
                ps = job.vz[vs_i];
                pe = job.vz[ve_i];
            end
        endcase
        diff = $signed({pe[31], pe}) - $signed({ps[31], ps});
        off  = prod_reg >>> FRAC_BITS;
        sum  = ps + off[31:0];
        cand = (cnt_reg == '0) ? rem_reg : {rem_reg[32:0], 1'b0};
        qbit = (cand >= {1'b0, aden_reg});
    end

    // first crossed pair of the current face
    always_comb
    begin
        seg_a    = '0;
        seg_b    = '0;
        fa_found = 1'b0;
        fb_found = 1'b0;
        f_stop   = 1'b0;
        fe       = '0;
        for (int i = 0; i < 4; i++)
        begin
            fe = face_edge(tet_reg, f_reg, 2'(i));
            if (!f_stop)
            begin
                if (fe == EDGE_NONE)
                begin
                    f_stop = 1'b1;
                end
                else if (crossed_reg[fe])
                begin
                    if (!fa_found)
                    begin
                        fa_found = 1'b1;
                        seg_a    = fe;
                    end
                    else
                    begin
                        fb_found = 1'b1;
                        seg_b    = fe;
                        f_stop   = 1'b1;
                    end
                end
            end
        end
    end

    // lowest unused segment touching the chain end
    always_comb
    begin
        c_found = 1'b0;
        cnext   = next_reg;
        c_sel   = '0;
        ca      = '0;
        cb      = '0;
        for (int i = 1; i < MAX_SEGMENTS; i++)
        begin
            ca = seg_reg[i][3:0];
            cb = seg_reg[i][7:4];
            if (!c_found && 3'(i) < nseg_reg && !used_reg[i])
            begin
                if (ca == next_reg)
                begin
                    c_found = 1'b1;
                    cnext   = cb;
                    c_sel   = 3'(i);
                end
                else if (cb == next_reg)
                begin
                    c_found = 1'b1;
                    cnext   = ca;
                    c_sel   = 3'(i);
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        e_next      = e_reg;
        ncross_next = ncross_reg;
        crossed_next = crossed_reg;
        order_next  = order_reg;
        npoly_next  = npoly_reg;
        k_next      = k_reg;
        nopoly_next = nopoly_reg;
        tet_next    = tet_reg;
        f_next      = f_reg;
        nseg_next   = nseg_reg;
        seg_next    = seg_reg;
        used_next   = used_reg;
        start_next  = start_reg;
        next_next   = next_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        aden_next   = aden_reg;
        crd_next    = crd_reg;
        prod_next   = prod_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        job_pop     = 1'b0;
        mem_we      = 1'b0;
        out_push    = 1'b0;
        out_item    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    tet_next     = job.tet;
                    e_next       = '0;
                    ncross_next  = '0;
                    crossed_next = '0;
                    state_next   = S_CHK;
                end
            end
            S_CHK:
            begin
                if (e_reg >= nedge)
                begin
                    job_pop = 1'b1;
                    k_next  = '0;
                    if (ncross_reg < 4'd3)
                    begin
                        nopoly_next = 1'b1;
                        state_next  = S_EMIT;
                    end
                    else if (ncross_reg == 4'd3)
                    begin
                        nopoly_next = 1'b0;
                        npoly_next  = 3'd3;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        f_next     = '0;
                        nseg_next  = '0;
                        state_next = S_SEG;
                    end
                end
                else if (edge_ok)
                begin
                    rem_next   = {1'b0, anum};
                    aden_next  = aden;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    e_next = e_reg + 4'd1;
                end
            end
            S_DIV:
            begin
                rem_next = qbit ? (cand - {1'b0, aden_reg}) : cand;
                q_next   = {q_reg[TW-2:0], qbit};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(TW - 1))
                begin
                    crd_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = PW'(diff) * PW'($signed({1'b0, q_reg}));
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (crd_reg == 2'd0)
                begin
                    px_next    = sum;
                    crd_next   = 2'd1;
                    state_next = S_MUL;
                end
                else if (crd_reg == 2'd1)
                begin
                    py_next    = sum;
                    crd_next   = 2'd2;
                    state_next = S_MUL;
                end
                else
                begin
                    mem_we = 1'b1;
                    crossed_next[e_reg] = 1'b1;
                    if (ncross_reg < 4'd3)
                    begin
                        order_next[ncross_reg[1:0]] = e_reg;
                    end
                    ncross_next = ncross_reg + 4'd1;
                    e_next      = e_reg + 4'd1;
                    state_next  = S_CHK;
                end
            end
            S_SEG:
            begin
                if (f_reg >= nface)
                begin
                    if (nseg_reg < 3'd4)
                    begin
                        nopoly_next = 1'b1;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        nopoly_next   = 1'b0;
                        start_next    = seg_reg[0][3:0];
                        next_next     = seg_reg[0][7:4];
                        order_next[0] = seg_reg[0][3:0];
                        order_next[1] = seg_reg[0][7:4];
                        npoly_next    = 3'd2;
                        used_next     = MAX_SEGMENTS'(1);
                        state_next    = S_CHN;
                    end
                end
                else
                begin
                    if (fb_found)
                    begin
                        seg_next[nseg_reg] = {seg_b, seg_a};
                        nseg_next          = nseg_reg + 3'd1;
                    end
                    f_next = f_reg + 3'd1;
                end
            end
            S_CHN:
            begin
                if (c_found)
                begin
                    used_next[c_sel]      = 1'b1;
                    order_next[npoly_reg] = cnext;
                    npoly_next            = npoly_reg + 3'd1;
                    next_next             = cnext;
                end
                else
                begin
                    if (next_reg == start_reg)
                    begin
                        npoly_next = npoly_reg - 3'd1;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (nopoly_reg)
                begin
                    if (!out_full)
                    begin
                        out_push      = 1'b1;
                        out_item.last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_EMWR;
                end
            end
            S_EMWR:
            begin
                out_item.x    = rd_reg[95:64];
                out_item.y    = rd_reg[63:32];
                out_item.z    = rd_reg[31:0];
                out_item.num  = k_reg;
                out_item.has  = 1'b1;
                out_item.last = (k_reg + 3'd1 == npoly_reg);
                if (!out_full)
                begin
                    out_push = 1'b1;
                    k_next   = k_reg + 3'd1;
                    state_next = out_item.last ? S_IDLE : S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // crossing point memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[e_reg] <= {px_reg, py_reg, sum};
        end
        if (state_reg == S_EMIT)
        begin
            rd_reg <= mem[order_reg[k_reg]];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        order_reg <= order_next;
        npoly_reg <= npoly_next;
        k_reg     <= k_next;
        f_reg     <= f_next;
        nseg_reg  <= nseg_next;
        seg_reg   <= seg_next;
        used_reg  <= used_next;
        start_reg <= start_next;
        next_reg  <= next_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        aden_reg  <= aden_next;
        crd_reg   <= crd_next;
        prod_reg  <= prod_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        e_reg     <= e_next;
        ncross_reg <= ncross_next;
        nopoly_reg <= nopoly_next;
        tet_reg   <= tet_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            crossed_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            crossed_reg <= crossed_next;
        end
    end

    a_emit_crossed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMWR |-> crossed_reg[order_reg[k_reg]])
        else $error("emitting an edge that was not crossed");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job popped while queue empty");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |=> state_reg == S_DIV || state_reg == S_MUL)
        else $error("divider left early");

endmodule

/* rtl/cell_isosurface_polygon.sv */
// cell_isosurface_polygon: top level joining the front, back and result queue
// depends on cip_pkg, cip_front, cip_back, cip_outq
//
// Usage: write iso_level, cell_type and min_denominator through the cfg port
// while idle. Push vertex words (push/full); the word with last_vertex high
// closes the cell and places a snapshot of its vertices into a two-entry job
// queue, so loading of the next cell overlaps the work on the current one.
// Results come out of a two-entry queue (empty/pop), one word per polygon point,
// or a single word with has_polygon low when the cell gives no polygon;
// last_point marks the final word of a cell.
// The time from the last vertex to the first point is set by the edge checks,
// the one-bit-per-cycle divider and the one shared multiplier used for three
// coordinates in turn, then by the face scan and the chain steps; each point
// then passes through the read state S_EMIT and the write state S_EMWR.
// Reset empties both queues and restores the register defaults.
// A stalled receiver fills the result queue and then holds the back part;
// the front keeps taking words until its job queue is full.
module cell_isosurface_polygon #(
    parameter int FRAC_BITS = cip_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         vertex_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] scalar_value,
    input  logic               last_vertex,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [2:0]         point_number,
    output logic               has_polygon,
    output logic               last_point
);
    import cip_pkg::*;

    logic       job_valid, job_pop, out_push, out_full;
    cip_job_t   job;
    cip_point_t out_item, head;

    cip_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .scalar_value (scalar_value),
        .last_vertex  (last_vertex),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop)
    );

    cip_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .out_push  (out_push),
        .out_item  (out_item),
        .out_full  (out_full)
    );

    cip_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_push  (out_push),
        .in_item  (out_item),
        .in_full  (out_full),
        .empty    (empty),
        .pop      (pop),
        .out_item (head)
    );

    // result fields
    assign point_x      = head.x;
    assign point_y      = head.y;
    assign point_z      = head.z;
    assign point_number = head.num;
    assign has_polygon  = head.has;
    assign last_point   = head.last;

endmodule
